// ===== hdl/psc_pkg.sv =====
// shared types, constants and register map of the pedometer step counter
package psc_pkg;

	// field widths
	localparam int RAW_W   = 16;
	localparam int MG_W    = 14;
	localparam int TIME_W  = 32;
	localparam int STEP_W  = 24;
	localparam int AXIS_W  = 2;
	localparam int RANGE_W = 2;
	localparam int SSIZE_W = 14;
	localparam int NUM_AXES = 3;

	// conversion and saturation limits
	localparam int          MG_SCALE = 1000;
	localparam logic [MG_W-1:0]   MG_MAX   = {MG_W{1'b1}};
	localparam logic [STEP_W-1:0] STEP_MAX = {STEP_W{1'b1}};

	// axis codes
	localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
	localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
	localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

	// register map
	localparam int APB_DW  = 32;
	localparam int PADDR_W = 4;
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_ACCEL_RANGE = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_MOVE_MIN    = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_WINDOW_US   = 2'd2;

	// register reset values
	localparam logic [RANGE_W-1:0] ACCEL_RANGE_RST = 2'd0;
	localparam logic [SSIZE_W-1:0] MOVE_MIN_RST    = 14'd200;
	localparam logic [TIME_W-1:0]  WINDOW_US_RST   = 32'd500000;

	// default moving average depth
	localparam int AVG_DEPTH_DEF = 4;

	// input beat
	typedef struct packed {
		logic signed [RAW_W-1:0] raw_x;
		logic signed [RAW_W-1:0] raw_y;
		logic signed [RAW_W-1:0] raw_z;
		logic [TIME_W-1:0]       time_us;
	} sample_t;

	// output beat
	typedef struct packed {
		logic [STEP_W-1:0] total_steps;
		logic              step_seen;
		logic [AXIS_W-1:0] axis_in_use;
	} result_t;

	// configuration seen by the datapath
	typedef struct packed {
		logic [RANGE_W-1:0] accel_range;
		logic [SSIZE_W-1:0] move_min;
		logic [TIME_W-1:0]  window_us;
	} cfg_t;

	// converted sample travelling from front to back
	typedef struct packed {
		logic [NUM_AXES-1:0][MG_W-1:0] mg;
		logic [TIME_W-1:0]             time_us;
	} mg_item_t;

endpackage

// ===== hdl/psc_regs.sv =====
// apb configuration registers of the pedometer step counter
module psc_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [psc_pkg::PADDR_W-1:0]   paddr,
	input  logic [psc_pkg::APB_DW-1:0]    pwdata,
	output logic [psc_pkg::APB_DW-1:0]    prdata,
	output logic                          pready,
	output psc_pkg::cfg_t                 cfg
);

	logic [psc_pkg::REG_IDX_W-1:0] idx;
	logic                          wr_en;
	psc_pkg::cfg_t                 cfg_q;

	assign idx    = paddr[psc_pkg::PADDR_W-1:2];
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.accel_range <= psc_pkg::ACCEL_RANGE_RST;
			cfg_q.move_min    <= psc_pkg::MOVE_MIN_RST;
			cfg_q.window_us   <= psc_pkg::WINDOW_US_RST;
		end else if (wr_en) begin
			unique case (idx)
				psc_pkg::REG_ACCEL_RANGE: begin
					cfg_q.accel_range <= pwdata[psc_pkg::RANGE_W-1:0];
				end
				psc_pkg::REG_MOVE_MIN: begin
					cfg_q.move_min <= pwdata[psc_pkg::SSIZE_W-1:0];
				end
				psc_pkg::REG_WINDOW_US: begin
					cfg_q.window_us <= pwdata[psc_pkg::TIME_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (idx)
			psc_pkg::REG_ACCEL_RANGE: begin
				prdata = psc_pkg::APB_DW'(cfg_q.accel_range);
			end
			psc_pkg::REG_MOVE_MIN: begin
				prdata = psc_pkg::APB_DW'(cfg_q.move_min);
			end
			psc_pkg::REG_WINDOW_US: begin
				prdata = psc_pkg::APB_DW'(cfg_q.window_us);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

endmodule

// ===== hdl/psc_front.sv =====
// front end: takes sample beats and converts each axis to milli-g
module psc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [psc_pkg::RANGE_W-1:0] accel_range,
	input  logic                 sample_valid,
	output logic                 sample_ready,
	input  psc_pkg::sample_t     sample,
	output logic                 item_valid,
	input  logic                 item_ready,
	output psc_pkg::mg_item_t    item
);

	localparam int MAG_W  = psc_pkg::RAW_W + 1;
	localparam int PROD_W = MAG_W + 10;
	localparam int SHL_W  = PROD_W + 4;

	logic signed [psc_pkg::RAW_W-1:0] raw [psc_pkg::NUM_AXES];
	logic [psc_pkg::NUM_AXES-1:0][psc_pkg::MG_W-1:0] mg;
	logic              valid_q;
	psc_pkg::mg_item_t item_q;
	logic              load;

	assign raw[0] = sample.raw_x;
	assign raw[1] = sample.raw_y;
	assign raw[2] = sample.raw_z;

	// magnitude times scale, shifted by full-scale select, saturated to 14 bits
	always_comb begin
		logic [MAG_W-1:0]  ext;
		logic [MAG_W-1:0]  mag;
		logic [PROD_W-1:0] prod;
		logic [SHL_W-1:0]  shl;
		logic [SHL_W-16:0] full;
		for (int a = 0; a < psc_pkg::NUM_AXES; a++) begin
			ext  = {raw[a][psc_pkg::RAW_W-1], raw[a]};
			mag  = raw[a][psc_pkg::RAW_W-1] ? (~ext + MAG_W'(1)) : ext;
			prod = PROD_W'(mag) * PROD_W'(psc_pkg::MG_SCALE);
			shl  = SHL_W'(prod) << (SHL_W'(accel_range) + SHL_W'(1));
			full = shl[SHL_W-1:15];
			mg[a] = (full > (SHL_W-15)'(psc_pkg::MG_MAX)) ? psc_pkg::MG_MAX
			        : full[psc_pkg::MG_W-1:0];
		end
	end

	assign sample_ready = ~valid_q | item_ready;
	assign load         = sample_valid & sample_ready;

	// holding register, refilled as soon as the queue takes the beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (sample_ready) begin
			valid_q <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_q.mg      <= mg;
			item_q.time_us <= sample.time_us;
		end
	end

	assign item_valid = valid_q;
	assign item       = item_q;

endmodule

// ===== hdl/psc_queue.sv =====
// two-entry queue between front and back
module psc_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_valid,
	output logic              wr_ready,
	input  psc_pkg::mg_item_t wr_data,
	output logic              rd_valid,
	input  logic              rd_ready,
	output psc_pkg::mg_item_t rd_data
);

	psc_pkg::mg_item_t entry_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;
	logic              push;
	logic              pop;

	assign wr_ready = (count_q != 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign push     = wr_valid & wr_ready;
	assign pop      = rd_valid & rd_ready;
	assign rd_data  = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ===== hdl/psc_back.sv =====
// back end: moving average, min/max tracking, window update and step detection
module psc_back #(
	parameter int AVG_DEPTH = psc_pkg::AVG_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  psc_pkg::cfg_t     cfg,
	input  logic              item_valid,
	output logic              item_ready,
	input  psc_pkg::mg_item_t item,
	output logic              result_valid,
	input  logic              result_ready,
	output psc_pkg::result_t  result
);

	localparam int MG_W    = psc_pkg::MG_W;
	localparam int NA      = psc_pkg::NUM_AXES;
	localparam int LOG_D   = $clog2(AVG_DEPTH);
	localparam int SUM_W   = MG_W + LOG_D;
	localparam int SLOT_W  = (AVG_DEPTH > 1) ? LOG_D : 1;
	localparam int K       = SUM_W + LOG_D;
	localparam int RECIP_W = SUM_W + 2;
	localparam int PROD_W  = SUM_W + RECIP_W;
	localparam int WORD_W  = NA * MG_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << K) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH));
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(AVG_DEPTH - 1);

	typedef logic [NA-1:0][MG_W-1:0] axes_t;

	logic en;

	// history memory and running sums
	logic [WORD_W-1:0]        hist_mem [AVG_DEPTH];
	logic [WORD_W-1:0]        hist_rd_q;
	logic [SLOT_W-1:0]        slot_q;
	logic [SLOT_W-1:0]        slot_nx;
	logic                     filled_q;
	logic [NA-1:0][SUM_W-1:0] sums_q;
	logic [NA-1:0][SUM_W-1:0] sums_nx;
	logic                     take;

	// pipeline registers
	logic                        valid_s1;
	logic [NA-1:0][SUM_W-1:0]    sum_s1;
	logic [psc_pkg::TIME_W-1:0]  time_s1;
	logic                        valid_s2;
	axes_t                       avg_s2;
	logic [psc_pkg::TIME_W-1:0]  time_s2;

	// detection state
	axes_t                        min_q;
	axes_t                        max_q;
	axes_t                        thr_q;
	logic [psc_pkg::AXIS_W-1:0]   axis_q;
	logic [MG_W-1:0]              last_q;
	logic [psc_pkg::TIME_W-1:0]   win_start_q;
	logic [psc_pkg::STEP_W-1:0]   steps_q;
	logic                         out_valid_q;
	psc_pkg::result_t             result_q;

	// detection next values
	axes_t                        min_nx;
	axes_t                        max_nx;
	axes_t                        thr_nx;
	logic [psc_pkg::AXIS_W-1:0]   axis_nx;
	logic [MG_W-1:0]              last_nx;
	logic [psc_pkg::STEP_W-1:0]   steps_nx;
	logic                         seen;
	logic                         win;
	logic                         upd;

	// whole back end moves together whenever the output slot can take a beat
	assign en         = ~out_valid_q | result_ready;
	assign item_ready = en;
	assign take       = en & item_valid;
	assign slot_nx    = (slot_q == LAST_SLOT) ? '0 : slot_q + SLOT_W'(1);

	// running sums: drop the oldest value, add the new one
	always_comb begin
		logic [MG_W-1:0] old;
		for (int a = 0; a < NA; a++) begin
			old = filled_q ? hist_rd_q[a*MG_W +: MG_W] : '0;
			sums_nx[a] = sums_q[a] - SUM_W'(old) + SUM_W'(item.mg[a]);
		end
	end

	// history write and look-ahead read of the next slot
	always_ff @(posedge clk) begin
		if (take) begin
			hist_mem[slot_q] <= item.mg;
			hist_rd_q        <= (slot_nx == slot_q) ? WORD_W'(item.mg) : hist_mem[slot_nx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q   <= '0;
			filled_q <= 1'b0;
			sums_q   <= '0;
		end else if (take) begin
			slot_q <= slot_nx;
			sums_q <= sums_nx;
			if (slot_q == LAST_SLOT) begin
				filled_q <= 1'b1;
			end
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= item_valid;
			valid_s2 <= valid_s1;
		end
	end

	// stage 1 carries the new sums, stage 2 divides them by the depth
	always_ff @(posedge clk) begin
		logic [PROD_W-1:0] prod;
		if (en) begin
			sum_s1  <= sums_nx;
			time_s1 <= item.time_us;
			time_s2 <= time_s1;
			for (int a = 0; a < NA; a++) begin
				prod = PROD_W'(sum_s1[a]) * PROD_W'(RECIP);
				avg_s2[a] <= MG_W'(prod >> K);
			end
		end
	end

	// window check, axis choice and step detection
	always_comb begin
		logic [psc_pkg::TIME_W-1:0] elapsed;
		axes_t                      mid;
		axes_t                      swing;
		logic [MG_W:0]              both;
		logic [psc_pkg::AXIS_W-1:0] pick;
		logic [MG_W-1:0]            old;
		logic [MG_W-1:0]            thr;
		logic [MG_W-1:0]            cur;
		logic [MG_W-1:0]            diff;
		elapsed = time_s2 - win_start_q;
		win     = (elapsed >= cfg.window_us);
		for (int a = 0; a < NA; a++) begin
			both     = {1'b0, min_q[a]} + {1'b0, max_q[a]};
			mid[a]   = both[MG_W:1];
			swing[a] = (max_q[a] >= min_q[a]) ? max_q[a] - min_q[a] : '0;
		end
		if (swing[0] >= swing[1] && swing[0] >= swing[2]) begin
			pick = psc_pkg::AXIS_X;
		end else if (swing[1] >= swing[2]) begin
			pick = psc_pkg::AXIS_Y;
		end else begin
			pick = psc_pkg::AXIS_Z;
		end
		if (win) begin
			thr_nx  = mid;
			min_nx  = avg_s2;
			max_nx  = avg_s2;
			axis_nx = pick;
			old     = (pick != axis_q) ? avg_s2[pick] : last_q;
			thr     = mid[pick];
		end else begin
			thr_nx  = thr_q;
			axis_nx = axis_q;
			old     = last_q;
			thr     = thr_q[axis_q];
			for (int a = 0; a < NA; a++) begin
				min_nx[a] = (min_q[a] > avg_s2[a]) ? avg_s2[a] : min_q[a];
				max_nx[a] = (max_q[a] < avg_s2[a]) ? avg_s2[a] : max_q[a];
			end
		end
		cur      = avg_s2[axis_nx];
		diff     = (cur > old) ? cur - old : old - cur;
		last_nx  = old;
		seen     = 1'b0;
		steps_nx = steps_q;
		if (diff > cfg.move_min) begin
			last_nx = cur;
			if (old > thr && cur < thr) begin
				seen = 1'b1;
				if (steps_q != psc_pkg::STEP_MAX) begin
					steps_nx = steps_q + psc_pkg::STEP_W'(1);
				end
			end
		end
	end

	assign upd = en & valid_s2;

	// detection state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q       <= '0;
			max_q       <= '0;
			thr_q       <= '0;
			axis_q      <= psc_pkg::AXIS_X;
			last_q      <= '0;
			win_start_q <= '0;
			steps_q     <= '0;
		end else if (upd) begin
			min_q   <= min_nx;
			max_q   <= max_nx;
			thr_q   <= thr_nx;
			axis_q  <= axis_nx;
			last_q  <= last_nx;
			steps_q <= steps_nx;
			if (win) begin
				win_start_q <= time_s2;
			end
		end
	end

	// output register, held while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			result_q.total_steps <= steps_nx;
			result_q.step_seen   <= seen;
			result_q.axis_in_use <= axis_nx;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = result_q;

endmodule

// ===== hdl/pedometer_step_counter.sv =====
// pedometer step counter: top level joining registers, front, queue and back
//
// sample channel: one beat per accelerometer reading (raw x/y/z and a
// microsecond timestamp), taken when sample_valid and sample_ready are high.
// result channel: one beat per sample, in order, with the step total, a flag
// for a step detected on that sample and the axis in use.
// path: a sample beat, once taken, passes the input register, queue, sum stage,
// divide stage and output register before its result is valid.
// throughput: one sample per cycle unless the receiver stalls; the running-sum
// update and the history memory port are each used once per sample.
// a stalled receiver holds the back end; the two-entry queue and the input
// register keep taking beats until they are full, then sample_ready drops.
// configuration: apb registers accel_range (0x0), minimum move (0x4) and
// window_us (0x8); write only while no sample is in flight.
// reset clears all sums, min/max, thresholds, the window start and the step
// total and loads the register defaults; history slots are not cleared: the
// oldest counts as zero until all slots are written; no clearing pass needed.
module pedometer_step_counter #(
	parameter int AVG_DEPTH = psc_pkg::AVG_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        sample_valid,
	output logic                        sample_ready,
	input  psc_pkg::sample_t            sample,
	output logic                        result_valid,
	input  logic                        result_ready,
	output psc_pkg::result_t            result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [psc_pkg::PADDR_W-1:0] paddr,
	input  logic [psc_pkg::APB_DW-1:0]  pwdata,
	output logic [psc_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);

	psc_pkg::cfg_t     cfg;
	logic              f_valid;
	logic              f_ready;
	psc_pkg::mg_item_t f_item;
	logic              q_valid;
	logic              q_ready;
	psc_pkg::mg_item_t q_item;

	// configuration registers
	psc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// conversion front end
	psc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accel_range  (cfg.accel_range),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.item_valid   (f_valid),
		.item_ready   (f_ready),
		.item         (f_item)
	);

	// decoupling queue
	psc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_data  (f_item),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_data  (q_item)
	);

	// averaging and step detection
	psc_back #(
		.AVG_DEPTH (AVG_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.item_valid   (q_valid),
		.item_ready   (q_ready),
		.item         (q_item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
